>>> src/vfv_pkg.sv
package vfv_pkg;

  // grid geometry
  localparam int GRID_SIZE = 16;
  localparam int ROWS      = GRID_SIZE * GRID_SIZE;
  localparam int CELLS     = ROWS * GRID_SIZE;
  localparam int ROW_AW    = $clog2(ROWS);
  localparam int CELL_AW   = $clog2(CELLS);
  localparam int XI_W      = $clog2(GRID_SIZE);

  // field widths
  localparam int COORD_W = 4;
  localparam int KIND_W  = 8;
  localparam int COUNT_W = 13;
  localparam int FACES   = 6;

  // face order in the visibility mask
  localparam int FACE_BACK   = 0;
  localparam int FACE_FRONT  = 1;
  localparam int FACE_LEFT   = 2;
  localparam int FACE_RIGHT  = 3;
  localparam int FACE_BOTTOM = 4;
  localparam int FACE_TOP    = 5;

  // command and result queues
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_NBR,
    ST_LAST
  } back_state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_z;
    logic [KIND_W-1:0]  block_kind;
    logic               cull_on;
  } in_item_t;

  typedef struct packed {
    logic               occupied;
    logic [KIND_W-1:0]  kind_out;
    logic [FACES-1:0]   face_mask;
    logic               enclosed;
    logic [COUNT_W-1:0] block_count;
  } res_t;

  // classified command, addresses already resolved
  typedef struct packed {
    op_e                op;
    logic               in_grid;
    logic               cull;
    logic [KIND_W-1:0]  kind;
    logic [CELL_AW-1:0] cell_addr;
    logic [ROW_AW-1:0]  row;
    logic [ROW_AW-1:0]  row_ym;
    logic [ROW_AW-1:0]  row_yp;
    logic [ROW_AW-1:0]  row_zm;
    logic [ROW_AW-1:0]  row_zp;
    logic [XI_W-1:0]    xi;
    logic [XI_W-1:0]    xi_m;
    logic [XI_W-1:0]    xi_p;
    logic [FACES-1:0]   at_edge;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

endpackage

>>> src/voxel_face_visibility_core.sv
// channel   direction  handshake            beat
// input     in         push / full          item_i   : op, cell, block_kind, cull_on
// result    out        empty / pop          result_o : occupancy, kind, face mask, count
//
// a query walks the back end states IDLE, ROW, NBR and LAST: five occupancy rows (own,
// y-1, y+1, z-1, z+1) come from the row store over its two read ports in three reads,
// the first in the issue cycle, and in LAST the mask is built and the result pushed
// set and delete: a row read, then a row write; no-op and off-grid items push at issue
// after reset the back end clears the occupancy store one row a cycle, all GRID_SIZE^2
// rows (256 here); full stays high until that pass ends
// a two-beat command queue and a two-beat result queue let input and output stall apart
module voxel_face_visibility_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input queue side
  input  logic               push,
  output logic               full,
  input  vfv_pkg::in_item_t  item_i,
  // result queue side
  output logic               empty,
  input  logic               pop,
  output vfv_pkg::res_t      result_o
);

  // front to back: head of the command queue
  vfv_pkg::cmd_head_t   head;
  // back to front: pop of the head and the clearing pass flag
  vfv_pkg::back_stat_t  stat;

  // front end: decode, range check, neighbour addressing, command queue
  vfv_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .item_i (item_i),
    .stat_i (stat),
    .head_o (head)
  );

  // back end: row store, kind store, count, sequencer and result queue
  vfv_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .stat_o   (stat),
    .pop_i    (pop),
    .empty_o  (empty),
    .result_o (result_o)
  );

endmodule

>>> src/vfv_front.sv
module vfv_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  output logic                   full_o,
  input  vfv_pkg::in_item_t      item_i,
  input  vfv_pkg::back_stat_t    stat_i,
  output vfv_pkg::cmd_head_t     head_o
);

  localparam int GridLast = vfv_pkg::GRID_SIZE - 1;

  vfv_pkg::cmd_t                   cls;
  vfv_pkg::cmd_t                   q_mem_q [vfv_pkg::QUEUE_DEPTH];
  logic [vfv_pkg::QPTR_W-1:0]      wptr_q, rptr_q;
  logic [vfv_pkg::QCNT_W-1:0]      cnt_q;
  logic                            wr_en, rd_en;

  // decode, range check, neighbour addresses with edge guards
  always_comb begin
    logic [vfv_pkg::ROW_AW-1:0] row;
    row = vfv_pkg::ROW_AW'(item_i.cell_z) * vfv_pkg::ROW_AW'(vfv_pkg::GRID_SIZE)
        + vfv_pkg::ROW_AW'(item_i.cell_y);
    cls = '0;
    cls.op      = vfv_pkg::op_e'(item_i.op);
    cls.in_grid = (32'(item_i.cell_x) <= 32'(GridLast))
               && (32'(item_i.cell_y) <= 32'(GridLast))
               && (32'(item_i.cell_z) <= 32'(GridLast));
    cls.cull   = item_i.cull_on;
    cls.kind   = item_i.block_kind;
    cls.at_edge[vfv_pkg::FACE_BACK]   = (item_i.cell_y == '0);
    cls.at_edge[vfv_pkg::FACE_FRONT]  = (32'(item_i.cell_y) == 32'(GridLast));
    cls.at_edge[vfv_pkg::FACE_LEFT]   = (item_i.cell_x == '0);
    cls.at_edge[vfv_pkg::FACE_RIGHT]  = (32'(item_i.cell_x) == 32'(GridLast));
    cls.at_edge[vfv_pkg::FACE_BOTTOM] = (item_i.cell_z == '0);
    cls.at_edge[vfv_pkg::FACE_TOP]    = (32'(item_i.cell_z) == 32'(GridLast));
    cls.row    = row;
    cls.row_ym = cls.at_edge[vfv_pkg::FACE_BACK]  ? row : row - vfv_pkg::ROW_AW'(1);
    cls.row_yp = cls.at_edge[vfv_pkg::FACE_FRONT] ? row : row + vfv_pkg::ROW_AW'(1);
    cls.row_zm = cls.at_edge[vfv_pkg::FACE_BOTTOM] ? row
               : row - vfv_pkg::ROW_AW'(vfv_pkg::GRID_SIZE);
    cls.row_zp = cls.at_edge[vfv_pkg::FACE_TOP] ? row
               : row + vfv_pkg::ROW_AW'(vfv_pkg::GRID_SIZE);
    cls.xi     = vfv_pkg::XI_W'(item_i.cell_x);
    cls.xi_m   = cls.at_edge[vfv_pkg::FACE_LEFT]  ? cls.xi : cls.xi - vfv_pkg::XI_W'(1);
    cls.xi_p   = cls.at_edge[vfv_pkg::FACE_RIGHT] ? cls.xi : cls.xi + vfv_pkg::XI_W'(1);
    cls.cell_addr = vfv_pkg::CELL_AW'(row) * vfv_pkg::CELL_AW'(vfv_pkg::GRID_SIZE)
                  + vfv_pkg::CELL_AW'(cls.xi);
  end

  // short command queue toward the back end
  assign full_o = (cnt_q == vfv_pkg::QCNT_W'(vfv_pkg::QUEUE_DEPTH)) | stat_i.clearing;
  assign wr_en  = push_i & ~full_o;
  assign rd_en  = stat_i.pop;

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = q_mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_en) begin
        wptr_q <= (wptr_q == vfv_pkg::QPTR_W'(vfv_pkg::QUEUE_DEPTH - 1)) ? '0
                : wptr_q + vfv_pkg::QPTR_W'(1);
      end
      if (rd_en) begin
        rptr_q <= (rptr_q == vfv_pkg::QPTR_W'(vfv_pkg::QUEUE_DEPTH - 1)) ? '0
                : rptr_q + vfv_pkg::QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + vfv_pkg::QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - vfv_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem_q[wptr_q] <= cls;
    end
  end

endmodule

>>> src/vfv_back.sv
module vfv_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vfv_pkg::cmd_head_t   head_i,
  output vfv_pkg::back_stat_t  stat_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output vfv_pkg::res_t        result_o
);

  localparam int RowW = vfv_pkg::GRID_SIZE;

  // occupancy rows (one bit per x) and per-cell kind
  logic [RowW-1:0]               occ_mem [vfv_pkg::ROWS];
  logic [vfv_pkg::KIND_W-1:0]    kind_mem [vfv_pkg::CELLS];

  vfv_pkg::back_state_e          state_q, state_d;
  vfv_pkg::cmd_t                 cur_q, cur_d;
  logic [vfv_pkg::ROW_AW-1:0]    clr_q, clr_d;
  logic [vfv_pkg::COUNT_W-1:0]   count_q, count_d;
  logic                          own_q, own_d;
  logic [vfv_pkg::FACES-1:0]     nb_q, nb_d, nb_fin;

  logic                          occ_re, occ_we, kind_re, kind_we;
  logic [vfv_pkg::ROW_AW-1:0]    occ_ra_a, occ_ra_b, occ_wa;
  logic [RowW-1:0]               occ_wd, rd_a_q, rd_b_q;
  logic [vfv_pkg::KIND_W-1:0]    kind_rd_q;

  logic                          start, needs_mem;

  vfv_pkg::res_t                 res_d;
  logic                          res_push, res_pop, res_full;
  vfv_pkg::res_t                 res_mem_q [vfv_pkg::QUEUE_DEPTH];
  logic [vfv_pkg::QPTR_W-1:0]    res_wptr_q, res_rptr_q;
  logic [vfv_pkg::QCNT_W-1:0]    res_cnt_q;

  assign res_full  = (res_cnt_q == vfv_pkg::QCNT_W'(vfv_pkg::QUEUE_DEPTH));
  assign start     = (state_q == vfv_pkg::ST_IDLE) && head_i.valid && !res_full;
  assign needs_mem = head_i.cmd.in_grid && (head_i.cmd.op != vfv_pkg::OP_NOP);

  assign stat_o.pop      = start;
  assign stat_o.clearing = (state_q == vfv_pkg::ST_CLEAR);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vfv_pkg::ST_CLEAR: begin
        if (clr_q == vfv_pkg::ROW_AW'(vfv_pkg::ROWS - 1)) begin
          state_d = vfv_pkg::ST_IDLE;
        end
      end
      vfv_pkg::ST_IDLE: begin
        if (start && needs_mem) begin
          state_d = vfv_pkg::ST_ROW;
        end
      end
      vfv_pkg::ST_ROW: begin
        state_d = (cur_q.op == vfv_pkg::OP_QUERY) ? vfv_pkg::ST_NBR : vfv_pkg::ST_IDLE;
      end
      vfv_pkg::ST_NBR:  state_d = vfv_pkg::ST_LAST;
      vfv_pkg::ST_LAST: state_d = vfv_pkg::ST_IDLE;
      default:          state_d = vfv_pkg::ST_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    occ_re   = 1'b0;
    occ_we   = 1'b0;
    kind_re  = 1'b0;
    kind_we  = 1'b0;
    occ_ra_a = head_i.cmd.row;
    occ_ra_b = head_i.cmd.row_ym;
    occ_wa   = cur_q.row;
    occ_wd   = rd_a_q;
    cur_d    = cur_q;
    clr_d    = clr_q;
    count_d  = count_q;
    own_d    = own_q;
    nb_d     = nb_q;
    nb_fin   = nb_q;
    res_push = 1'b0;
    res_d    = '0;
    res_d.block_count = count_q;
    unique case (state_q)
      vfv_pkg::ST_CLEAR: begin
        occ_we = 1'b1;
        occ_wa = clr_q;
        occ_wd = '0;
        clr_d  = clr_q + vfv_pkg::ROW_AW'(1);
      end
      vfv_pkg::ST_IDLE: begin
        if (start) begin
          cur_d = head_i.cmd;
          if (needs_mem) begin
            occ_re  = 1'b1;
            kind_re = 1'b1;
          end else begin
            res_push = 1'b1;
          end
        end
      end
      vfv_pkg::ST_ROW: begin
        if (cur_q.op == vfv_pkg::OP_QUERY) begin
          own_d = rd_a_q[cur_q.xi];
          nb_d[vfv_pkg::FACE_LEFT]  = ~cur_q.at_edge[vfv_pkg::FACE_LEFT]  & rd_a_q[cur_q.xi_m];
          nb_d[vfv_pkg::FACE_RIGHT] = ~cur_q.at_edge[vfv_pkg::FACE_RIGHT] & rd_a_q[cur_q.xi_p];
          nb_d[vfv_pkg::FACE_BACK]  = ~cur_q.at_edge[vfv_pkg::FACE_BACK]  & rd_b_q[cur_q.xi];
          occ_re   = 1'b1;
          occ_ra_a = cur_q.row_yp;
          occ_ra_b = cur_q.row_zm;
        end else begin
          // read-modify-write of the cell's row
          occ_we = 1'b1;
          occ_wd[cur_q.xi] = (cur_q.op == vfv_pkg::OP_SET);
          if (cur_q.op == vfv_pkg::OP_SET) begin
            kind_we = 1'b1;
            if (!rd_a_q[cur_q.xi]) begin
              count_d = count_q + vfv_pkg::COUNT_W'(1);
            end
          end else if (rd_a_q[cur_q.xi] && (count_q != '0)) begin
            count_d = count_q - vfv_pkg::COUNT_W'(1);
          end
          res_push = 1'b1;
          res_d.block_count = count_d;
        end
      end
      vfv_pkg::ST_NBR: begin
        nb_d[vfv_pkg::FACE_FRONT]  = ~cur_q.at_edge[vfv_pkg::FACE_FRONT]  & rd_a_q[cur_q.xi];
        nb_d[vfv_pkg::FACE_BOTTOM] = ~cur_q.at_edge[vfv_pkg::FACE_BOTTOM] & rd_b_q[cur_q.xi];
        occ_re   = 1'b1;
        occ_ra_a = cur_q.row_zp;
      end
      vfv_pkg::ST_LAST: begin
        nb_fin[vfv_pkg::FACE_TOP] = ~cur_q.at_edge[vfv_pkg::FACE_TOP] & rd_a_q[cur_q.xi];
        res_push = 1'b1;
        res_d.occupied  = own_q;
        res_d.kind_out  = own_q ? kind_rd_q : '0;
        res_d.face_mask = own_q ? (~nb_fin | {vfv_pkg::FACES{~cur_q.cull}}) : '0;
        // edge neighbours already read as empty, so this also covers the boundary
        res_d.enclosed  = &nb_fin;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vfv_pkg::ST_CLEAR;
      clr_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    own_q <= own_d;
    nb_q  <= nb_d;
  end

  // occupancy store: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    if (occ_re) begin
      rd_a_q <= occ_mem[occ_ra_a];
      rd_b_q <= occ_mem[occ_ra_b];
    end
  end

  // kind store
  always_ff @(posedge clk_i) begin
    if (kind_we) begin
      kind_mem[cur_q.cell_addr] <= cur_q.kind;
    end
    if (kind_re) begin
      kind_rd_q <= kind_mem[head_i.cmd.cell_addr];
    end
  end

  // result queue
  assign res_pop  = pop_i & ~empty_o;
  assign empty_o  = (res_cnt_q == '0);
  assign result_o = res_mem_q[res_rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wptr_q <= '0;
      res_rptr_q <= '0;
      res_cnt_q  <= '0;
    end else begin
      if (res_push) begin
        res_wptr_q <= (res_wptr_q == vfv_pkg::QPTR_W'(vfv_pkg::QUEUE_DEPTH - 1)) ? '0
                    : res_wptr_q + vfv_pkg::QPTR_W'(1);
      end
      if (res_pop) begin
        res_rptr_q <= (res_rptr_q == vfv_pkg::QPTR_W'(vfv_pkg::QUEUE_DEPTH - 1)) ? '0
                    : res_rptr_q + vfv_pkg::QPTR_W'(1);
      end
      if (res_push && !res_pop) begin
        res_cnt_q <= res_cnt_q + vfv_pkg::QCNT_W'(1);
      end else if (res_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - vfv_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[res_wptr_q] <= res_d;
    end
  end

endmodule
